>>> rtl/core/slrg_pkg.sv
// ============================================================================
// slrg_pkg
// Shared constants, types and arithmetic helpers for the subtractive lagged
// random generator.
// ============================================================================
package slrg_pkg;

    localparam int VAL_W  = 30;
    localparam int SEED_W = 28;
    localparam int PTR_W  = 6;

    localparam int TABLE_LEN   = 55;
    localparam int FILL_STRIDE = 21;
    localparam int WARM_OFFSET = 30;
    localparam int WARM_PASSES = 4;
    localparam int PASS_W      = $clog2(WARM_PASSES);

    localparam logic [VAL_W-1:0] MODULUS   = 30'd1000000000;
    localparam logic [VAL_W-1:0] SEED_BASE = 30'd161803398;

    // Datapath controls issued by the sequencer.
    typedef struct packed {
        logic fill_load;   // start the seeding chain from the clamped seed
        logic fill_step;   // advance the seeding chain, write data is its value
        logic cap_a;       // capture the first operand from the table
        logic out_load;    // load the difference into the output register
    } t_dp_ctrl;

    // (a - b) mod MODULUS for a and b below MODULUS.
    function automatic logic [VAL_W-1:0] mod_sub(input logic [VAL_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
        logic [VAL_W:0] t;
        t = {1'b0, a} - {1'b0, b};
        if (t[VAL_W]) begin
            return t[VAL_W-1:0] + MODULUS;
        end
        return t[VAL_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        return (p >= PTR_W'(TABLE_LEN - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

>>> rtl/core/slrg_ram.sv
// ============================================================================
// slrg_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read that holds its data while no read is issued.
// ============================================================================
module slrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/slrg_diff.sv
// ============================================================================
// slrg_diff
// Datapath: the seeding chain, the first-operand register, the shared
// modular subtractor and the output data register.
// ============================================================================
module slrg_diff (
    input  logic                           i_clk,
    input  slrg_pkg::t_dp_ctrl             i_dp,
    input  logic [slrg_pkg::SEED_W-1:0]    i_seed,
    input  logic [slrg_pkg::VAL_W-1:0]     i_rdata,
    output logic [slrg_pkg::VAL_W-1:0]     o_wdata,
    output logic [slrg_pkg::VAL_W-1:0]     o_out_data
);
    import slrg_pkg::*;

    logic [VAL_W-1:0] r_fcur;
    logic [VAL_W-1:0] r_fprev;
    logic [VAL_W-1:0] r_a;
    logic [VAL_W-1:0] r_out;
    logic [VAL_W-1:0] seed_ext;
    logic [VAL_W-1:0] fill_base;
    logic [VAL_W-1:0] op_a;
    logic [VAL_W-1:0] op_b;
    logic [VAL_W-1:0] diff;

    // Seeds above the base constant are clamped, which makes the start zero.
    assign seed_ext  = VAL_W'(i_seed);
    assign fill_base = (seed_ext > SEED_BASE) ? '0 : SEED_BASE - seed_ext;

    assign op_a = i_dp.fill_step ? r_fprev : r_a;
    assign op_b = i_dp.fill_step ? r_fcur  : i_rdata;
    assign diff = mod_sub(op_a, op_b);

    always_ff @(posedge i_clk) begin
        if (i_dp.fill_load) begin
            r_fprev <= fill_base;
            r_fcur  <= VAL_W'(1);
        end else if (i_dp.fill_step) begin
            r_fprev <= r_fcur;
            r_fcur  <= diff;
        end
        if (i_dp.cap_a) begin
            r_a <= i_rdata;
        end
        if (i_dp.out_load) begin
            r_out <= diff;
        end
    end

    assign o_wdata    = i_dp.fill_step ? r_fcur : diff;
    assign o_out_data = r_out;

endmodule

>>> rtl/core/slrg_seq.sv
// ============================================================================
// slrg_seq
// Sequencer: seeding fill, warm-up passes and draws over the lag table,
// with the ring pointers and the output valid flag.
// ============================================================================
module slrg_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_draw,
    output logic                        o_in_ready,
    input  logic                        i_out_ready,
    output logic                        o_out_valid,
    output slrg_pkg::t_dp_ctrl          o_dp,
    output logic                        o_we,
    output logic [slrg_pkg::PTR_W-1:0]  o_waddr,
    output logic                        o_re,
    output logic [slrg_pkg::PTR_W-1:0]  o_raddr
);
    import slrg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_FILL, S_RA, S_RB, S_WR} t_state;

    t_state             r_state, n_state;
    logic               r_seeded, n_seeded;
    logic [PTR_W-1:0]   r_lead, n_lead;
    logic [PTR_W-1:0]   r_trail, n_trail;
    logic [PTR_W-1:0]   r_wi, n_wi;
    logic [PASS_W-1:0]  r_pass, n_pass;
    logic [PTR_W-1:0]   r_fidx, n_fidx;
    logic [PTR_W-1:0]   r_fcnt, n_fcnt;
    logic               r_op_draw, n_op_draw;
    logic               r_out_valid, n_out_valid;

    logic               can_finish;
    logic               accept;
    logic [PTR_W-1:0]   lead_nx;
    logic [PTR_W-1:0]   trail_nx;
    logic [PTR_W-1:0]   warm_partner;
    logic [PTR_W:0]     fill_sum;

    assign can_finish = !r_out_valid || i_out_ready;
    assign lead_nx    = ring_next(r_lead);
    assign trail_nx   = ring_next(r_trail);
    assign warm_partner = (r_wi < PTR_W'(TABLE_LEN - WARM_OFFSET))
                        ? r_wi + PTR_W'(WARM_OFFSET)
                        : r_wi - PTR_W'(TABLE_LEN - WARM_OFFSET);
    assign fill_sum   = {1'b0, r_fidx} + (PTR_W+1)'(FILL_STRIDE);

    assign o_in_ready = (r_state == S_IDLE) || (r_state == S_WR && r_op_draw && can_finish);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state     = r_state;
        n_seeded    = r_seeded;
        n_lead      = r_lead;
        n_trail     = r_trail;
        n_wi        = r_wi;
        n_pass      = r_pass;
        n_fidx      = r_fidx;
        n_fcnt      = r_fcnt;
        n_op_draw   = r_op_draw;
        n_out_valid = r_out_valid && !i_out_ready;
        o_dp        = '0;
        o_we        = 1'b0;
        o_waddr     = '0;
        o_re        = 1'b0;
        o_raddr     = '0;

        case (r_state)
            S_IDLE: begin
                if (accept && i_in_draw) begin
                    if (r_seeded) begin
                        n_lead    = lead_nx;
                        n_trail   = trail_nx;
                        o_re      = 1'b1;
                        o_raddr   = lead_nx;
                        n_op_draw = 1'b1;
                        n_state   = S_RB;
                    end else begin
                        o_dp.fill_load = 1'b1;
                        n_fidx  = PTR_W'(FILL_STRIDE);
                        n_fcnt  = PTR_W'(1);
                        n_state = S_FILL;
                    end
                end
            end
            S_FILL: begin
                // The fill walks all entries in stride order, so no reads occur.
                o_we           = 1'b1;
                o_waddr        = r_fidx;
                o_dp.fill_step = 1'b1;
                n_fidx = (fill_sum >= (PTR_W+1)'(TABLE_LEN))
                       ? PTR_W'(fill_sum - (PTR_W+1)'(TABLE_LEN))
                       : fill_sum[PTR_W-1:0];
                n_fcnt = r_fcnt + 1'b1;
                if (r_fcnt == PTR_W'(TABLE_LEN)) begin
                    n_wi    = '0;
                    n_pass  = '0;
                    n_state = S_RA;
                end
            end
            S_RA: begin
                o_re      = 1'b1;
                o_raddr   = r_wi;
                n_op_draw = 1'b0;
                n_state   = S_RB;
            end
            S_RB: begin
                o_dp.cap_a = 1'b1;
                o_re       = 1'b1;
                o_raddr    = r_op_draw ? r_trail : warm_partner;
                n_state    = S_WR;
            end
            S_WR: begin
                if (!r_op_draw) begin
                    o_we    = 1'b1;
                    o_waddr = r_wi;
                    if (r_wi == PTR_W'(TABLE_LEN - 1)) begin
                        n_wi = '0;
                        if (r_pass == PASS_W'(WARM_PASSES - 1)) begin
                            // Warm-up done: continue with the draw that started seeding.
                            n_seeded  = 1'b1;
                            n_lead    = lead_nx;
                            n_trail   = trail_nx;
                            o_re      = 1'b1;
                            o_raddr   = lead_nx;
                            n_op_draw = 1'b1;
                        end else begin
                            n_pass  = r_pass + 1'b1;
                            o_re    = 1'b1;
                            o_raddr = '0;
                        end
                    end else begin
                        n_wi    = r_wi + 1'b1;
                        o_re    = 1'b1;
                        o_raddr = r_wi + 1'b1;
                    end
                    n_state = S_RB;
                end else if (can_finish) begin
                    o_we          = 1'b1;
                    o_waddr       = r_lead;
                    o_dp.out_load = 1'b1;
                    n_out_valid   = 1'b1;
                    if (accept && i_in_draw) begin
                        n_lead  = lead_nx;
                        n_trail = trail_nx;
                        o_re    = 1'b1;
                        o_raddr = lead_nx;
                        n_state = S_RB;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_seeded    <= 1'b0;
            r_lead      <= PTR_W'(TABLE_LEN - 1);
            r_trail     <= PTR_W'(WARM_OFFSET);
            r_wi        <= '0;
            r_pass      <= '0;
            r_fidx      <= '0;
            r_fcnt      <= '0;
            r_op_draw   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seeded    <= n_seeded;
            r_lead      <= n_lead;
            r_trail     <= n_trail;
            r_wi        <= n_wi;
            r_pass      <= n_pass;
            r_fidx      <= n_fidx;
            r_fcnt      <= n_fcnt;
            r_op_draw   <= n_op_draw;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/subtractive_lagged_random_generator.sv
// ============================================================================
// subtractive_lagged_random_generator
// Subtractive lagged generator over a 55-entry table of residues modulo one
// billion, held in one simple dual-port RAM.
// ============================================================================
// Usage:
// Each word on the slave stream with bit 0 of tdata set asks for one number;
// a word with bit 0 clear is taken and ignored. Every request gives one
// word on the master stream, a value below one billion in tdata bits 29:0.
// The seed magnitude is written on the configuration channel, which is
// always ready; it is sampled only by the first request after reset.
// That first request seeds the table: a fill of all 55 entries, one read and
// 220 warm-up updates, before its own draw. A later request may be taken
// while the previous result is written, and the single read port fetches
// two table entries per result. Reset returns the ring pointers to their
// start values and clears the seeded state; the table itself is rewritten
// by the next seeding. When the receiver stalls, the result holds in the
// output register, one more request may be taken, and its table update
// waits until the output register frees up.
// ============================================================================
module subtractive_lagged_random_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,   // [0] draw_request
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [31:0]                 m_axis_tdata,   // [29:0] random_value
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [slrg_pkg::SEED_W-1:0] i_cfg_data
);
    import slrg_pkg::*;

    logic [SEED_W-1:0] r_seed;
    t_dp_ctrl          dp;
    logic              we;
    logic              re;
    logic [PTR_W-1:0]  waddr;
    logic [PTR_W-1:0]  raddr;
    logic [VAL_W-1:0]  wdata;
    logic [VAL_W-1:0]  rdata;
    logic [VAL_W-1:0]  out_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (i_cfg_valid) begin
            r_seed <= i_cfg_data;
        end
    end

    slrg_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_draw   (s_axis_tdata[0]),
        .o_in_ready  (s_axis_tready),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_dp        (dp),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_re        (re),
        .o_raddr     (raddr)
    );

    slrg_diff u_diff (
        .i_clk      (i_clk),
        .i_dp       (dp),
        .i_seed     (r_seed),
        .i_rdata    (rdata),
        .o_wdata    (wdata),
        .o_out_data (out_data)
    );

    slrg_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_LEN)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign m_axis_tdata = {2'b00, out_data};

endmodule

>>> rtl/core/slrg_checker.sv
// ============================================================================
// slrg_checker
// Port-level checks for the subtractive lagged random generator, bound to
// the top level.
// ============================================================================
module slrg_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic [7:0]                  s_axis_tdata,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [31:0]                 m_axis_tdata,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready
);
    import slrg_pkg::*;

    // A stalled result word keeps its valid and its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // A request word that waits for acceptance stays offered and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid && $stable(s_axis_tdata))
        else $error("waiting request word changed");

    // Every result is a residue below the modulus with clear pad bits.
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[29:0] < MODULUS) && (m_axis_tdata[31:30] == 2'b00))
        else $error("result word out of range");

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // The configuration channel never pushes back.
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("configuration write refused");

endmodule

bind subtractive_lagged_random_generator slrg_checker u_slrg_checker (.*);

>>> tb/tb_subtractive_lagged_random_generator.sv
// ----------------------------------------------------------------------------
// tb_subtractive_lagged_random_generator
// Self-checking bench for the subtractive lagged random generator. A table
// of directed words runs first: request and no-request words, the seeding
// draw and seed writes after seeding. Random words follow, in three phases
// with different idle rates on each stream. Every result word is compared
// with a predictor that keeps its own copy of the 55-entry lag table.
// ----------------------------------------------------------------------------
module tb_subtractive_lagged_random_generator;

    timeunit 1ns;
    timeprecision 1ps;

    localparam real CLK_PERIOD   = 8.0;
    localparam int  RESET_CYCLES = 6;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RAND_WORDS   = 930;
    localparam int  IDLE_SETTLE  = 12;
    localparam int  END_SETTLE   = 40;
    localparam int  RX_HOLD      = 300;
    localparam int  DIR_ROWS     = 20;

    localparam longint MOD_VAL     = 64'd1000000000;
    localparam int     SEED_CLAMP  = 161803398;
    localparam int     RING_LEN    = 55;
    localparam int     FILL_STEP   = 21;
    localparam int     WARM_LAG    = 30;
    localparam int     WARM_ROUNDS = 4;

    localparam logic [slrg_pkg::SEED_W-1:0] SEED_ALL_ONES = '1;

    typedef enum logic [1:0] {
        ROW_DRAW,   // word with the request bit set
        ROW_SKIP,   // word with the request bit clear
        ROW_SEED    // seed write once the block has drained
    } t_row_kind;

    typedef struct packed {
        t_row_kind                   kind;
        logic [slrg_pkg::SEED_W-1:0] value;
    } t_dir_row;

    // A no-request word comes before the seeding draw, so it must not seed.
    // Seed writes after seeding must leave the sequence untouched.
    t_dir_row directed_rows [DIR_ROWS] = '{
        '{ROW_SKIP, '0},
        '{ROW_DRAW, '0},
        '{ROW_DRAW, '0},
        '{ROW_SKIP, '0},
        '{ROW_DRAW, '0},
        '{ROW_SKIP, '0},
        '{ROW_SKIP, '0},
        '{ROW_DRAW, '0},
        '{ROW_SEED, '0},
        '{ROW_DRAW, '0},
        '{ROW_SEED, SEED_ALL_ONES},
        '{ROW_DRAW, '0},
        '{ROW_DRAW, '0},
        '{ROW_SEED, slrg_pkg::SEED_W'(SEED_CLAMP)},
        '{ROW_DRAW, '0},
        '{ROW_DRAW, '0},
        '{ROW_SKIP, '0},
        '{ROW_DRAW, '0},
        '{ROW_SEED, slrg_pkg::SEED_W'(SEED_CLAMP + 1)},
        '{ROW_DRAW, '0}
    };

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic                        s_axis_tready;
    logic [7:0]                  s_axis_tdata  = '0;   // [0] draw_request
    logic                        m_axis_tvalid;
    logic                        m_axis_tready = 1'b0;
    logic [31:0]                 m_axis_tdata;         // [29:0] random_value
    logic                        i_cfg_valid   = 1'b0;
    logic                        o_cfg_ready;
    logic [slrg_pkg::SEED_W-1:0] i_cfg_data    = '0;

    // Predictor state.
    logic [slrg_pkg::VAL_W-1:0]  lag_tab [RING_LEN];
    int                          lead_ix;
    int                          trail_ix;
    bit                          table_seeded;
    logic [slrg_pkg::SEED_W-1:0] seed_reg;

    logic [slrg_pkg::VAL_W-1:0]  pending_values [$];
    int                          mismatch_count = 0;
    int                          cycle_count    = 0;
    int                          tx_idle_pct    = 0;
    int                          rx_idle_pct    = 0;
    int                          rx_hold_left   = 0;

    subtractive_lagged_random_generator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2.0) i_clk = ~i_clk;

    function automatic logic [slrg_pkg::VAL_W-1:0] sub_mod(
        input logic [slrg_pkg::VAL_W-1:0] a,
        input logic [slrg_pkg::VAL_W-1:0] b
    );
        longint t;
        t = longint'(a) - longint'(b);
        if (t < 0) begin
            t = t + MOD_VAL;
        end
        return t[slrg_pkg::VAL_W-1:0];
    endfunction

    function automatic int ring_step(input int p);
        return (p >= RING_LEN - 1) ? 0 : p + 1;
    endfunction

    function automatic void seed_lag_table();
        int                         s;
        int                         idx;
        logic [slrg_pkg::VAL_W-1:0] prev;
        logic [slrg_pkg::VAL_W-1:0] cur;
        s = int'(seed_reg);
        if (s > SEED_CLAMP) begin
            s = SEED_CLAMP;
        end
        prev = slrg_pkg::VAL_W'(SEED_CLAMP - s);
        lag_tab[RING_LEN-1] = prev;
        cur = slrg_pkg::VAL_W'(1);
        for (int i = 1; i <= RING_LEN; i++) begin
            idx = (FILL_STEP * i) % RING_LEN;
            lag_tab[idx] = cur;
            cur = sub_mod(prev, cur);
            prev = lag_tab[idx];
        end
        for (int k = 0; k < WARM_ROUNDS; k++) begin
            for (int i = 0; i < RING_LEN; i++) begin
                lag_tab[i] = sub_mod(lag_tab[i], lag_tab[(i + WARM_LAG) % RING_LEN]);
            end
        end
        lead_ix      = RING_LEN - 1;
        trail_ix     = WARM_LAG;
        table_seeded = 1'b1;
    endfunction

    function automatic logic [slrg_pkg::VAL_W-1:0] draw_next_value();
        logic [slrg_pkg::VAL_W-1:0] v;
        if (!table_seeded) begin
            seed_lag_table();
        end
        lead_ix  = ring_step(lead_ix);
        trail_ix = ring_step(trail_ix);
        v = sub_mod(lag_tab[lead_ix], lag_tab[trail_ix]);
        lag_tab[lead_ix] = v;
        return v;
    endfunction

    // All driving tasks start and end at a falling edge.
    task automatic push_word(input logic req);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, req};
        do @(posedge i_clk); while (!s_axis_tready);
        if (req) begin
            pending_values.push_back(draw_next_value());
        end
        @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [slrg_pkg::SEED_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        seed_reg = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // Stop offering words and let every pending result come out.
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (IDLE_SETTLE) @(negedge i_clk);
    endtask

    // Rates and the hold-off change at a rising edge, clear of the receiver.
    task automatic enter_phase(input int tx_pct, input int rx_pct, input int hold);
        @(posedge i_clk);
        tx_idle_pct  = tx_pct;
        rx_idle_pct  = rx_pct;
        rx_hold_left = hold;
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        if (rx_hold_left > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        logic [slrg_pkg::VAL_W-1:0] want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_values.size() == 0) begin
                $error("unexpected result word: random_value actual %0d",
                       m_axis_tdata[slrg_pkg::VAL_W-1:0]);
                mismatch_count++;
            end else begin
                want = pending_values.pop_front();
                if (m_axis_tdata[slrg_pkg::VAL_W-1:0] !== want) begin
                    $error("random_value mismatch: expected %0d actual %0d",
                           want, m_axis_tdata[slrg_pkg::VAL_W-1:0]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial begin : stimulus
        int          words;
        logic        req;
        int          tx_pct [3];
        int          rx_pct [3];
        tx_pct = '{23, 63, 0};
        rx_pct = '{63, 23, 0};

        seed_reg     = '0;
        lead_ix      = RING_LEN - 1;
        trail_ix     = WARM_LAG;
        table_seeded = 1'b0;
        foreach (lag_tab[i]) begin
            lag_tab[i] = '0;
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Only the last write before the first draw takes effect.
        write_seed(SEED_ALL_ONES);
        write_seed('0);
        case ($urandom_range(3))
            0: write_seed('0);
            1: write_seed(slrg_pkg::SEED_W'(SEED_CLAMP));
            2: write_seed(SEED_ALL_ONES);
            default: write_seed(slrg_pkg::SEED_W'($urandom_range(SEED_CLAMP)));
        endcase

        enter_phase(15, 30, 0);
        foreach (directed_rows[r]) begin
            case (directed_rows[r].kind)
                ROW_DRAW: push_word(1'b1);
                ROW_SKIP: push_word(1'b0);
                default: begin
                    drain_block();
                    write_seed(directed_rows[r].value);
                end
            endcase
        end

        for (int ph = 0; ph < 3; ph++) begin
            drain_block();
            write_seed(slrg_pkg::SEED_W'($urandom()));
            // The long receiver hold-off comes with a sender that never idles,
            // so the block fills and stalls its input.
            enter_phase(tx_pct[ph], rx_pct[ph], (ph == 2) ? RX_HOLD : 0);
            words = 0;
            while (words < (RAND_WORDS + 2) / 3) begin
                req = ($urandom_range(9) != 0);
                push_word(req);
                words++;
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_values.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (END_SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && pending_values.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/slrg_pkg.sv
rtl/core/slrg_ram.sv
rtl/core/slrg_diff.sv
rtl/core/slrg_seq.sv
rtl/core/subtractive_lagged_random_generator.sv
rtl/core/slrg_checker.sv
tb/tb_subtractive_lagged_random_generator.sv
